// ===== design/acd_pkg.sv =====
// ============================================================================
// Avro container deframer package
// Phase codes, result kinds, error codes and key name tables.
// ============================================================================
package acd_pkg;

    localparam logic [3:0] PH_MAGIC   = 4'd0;
    localparam logic [3:0] PH_MCOUNT  = 4'd1;
    localparam logic [3:0] PH_MSIZE   = 4'd2;
    localparam logic [3:0] PH_KLEN    = 4'd3;
    localparam logic [3:0] PH_KBYTES  = 4'd4;
    localparam logic [3:0] PH_VLEN    = 4'd5;
    localparam logic [3:0] PH_VBYTES  = 4'd6;
    localparam logic [3:0] PH_HSYNC   = 4'd7;
    localparam logic [3:0] PH_BCOUNT  = 4'd8;
    localparam logic [3:0] PH_BLEN    = 4'd9;
    localparam logic [3:0] PH_PAYLOAD = 4'd10;
    localparam logic [3:0] PH_BSYNC   = 4'd11;
    localparam logic [3:0] PH_DONE    = 4'd12;

    localparam logic [2:0] KIND_HDR_DONE = 3'd0;
    localparam logic [2:0] KIND_BLOCK    = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
    localparam logic [2:0] KIND_SYNC_OK  = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_MAGIC  = 3'd1;
    localparam logic [2:0] ERR_VARINT = 3'd2;
    localparam logic [2:0] ERR_RANGE  = 3'd3;
    localparam logic [2:0] ERR_SCHEMA = 3'd4;
    localparam logic [2:0] ERR_CODEC  = 3'd5;
    localparam logic [2:0] ERR_SYNC   = 3'd6;

    localparam logic [1:0] REG_FILE_LENGTH = 2'd0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  pbyte;
        logic [31:0] rcount;
        logic [31:0] blen;
        logic        zstd;
        logic [2:0]  err;
        logic        done;
    } result_t;

    function automatic logic [7:0] magic_at(input logic [1:0] i);
        case (i)
            2'd0:    magic_at = 8'h4F;
            2'd1:    magic_at = 8'h62;
            2'd2:    magic_at = 8'h6A;
            default: magic_at = 8'h01;
        endcase
    endfunction

    function automatic logic [7:0] schema_at(input logic [3:0] i);
        case (i)
            4'd0: schema_at = "a";  4'd1: schema_at = "v";  4'd2: schema_at = "r";
            4'd3: schema_at = "o";  4'd4: schema_at = ".";  4'd5: schema_at = "s";
            4'd6: schema_at = "c";  4'd7: schema_at = "h";  4'd8: schema_at = "e";
            4'd9: schema_at = "m";  4'd10: schema_at = "a";
            default: schema_at = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] codec_at(input logic [3:0] i);
        case (i)
            4'd0: codec_at = "a";  4'd1: codec_at = "v";  4'd2: codec_at = "r";
            4'd3: codec_at = "o";  4'd4: codec_at = ".";  4'd5: codec_at = "c";
            4'd6: codec_at = "o";  4'd7: codec_at = "d";  4'd8: codec_at = "e";
            4'd9: codec_at = "c";
            default: codec_at = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] null_at(input logic [3:0] i);
        case (i)
            4'd0: null_at = "n";  4'd1: null_at = "u";
            4'd2: null_at = "l";  4'd3: null_at = "l";
            default: null_at = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] zstd_at(input logic [3:0] i);
        case (i)
            4'd0: zstd_at = "z";  4'd1: zstd_at = "s";  4'd2: zstd_at = "t";
            4'd3: zstd_at = "a";  4'd4: zstd_at = "n";  4'd5: zstd_at = "d";
            4'd6: zstd_at = "a";  4'd7: zstd_at = "r";  4'd8: zstd_at = "d";
            default: zstd_at = 8'h00;
        endcase
    endfunction

endpackage

// ===== design/avro_container_deframer.sv =====
// ============================================================================
// Avro container deframer
// Parses the container header and frames data blocks, one byte per transfer.
// ============================================================================
// The block takes one file byte per clock while s_tready is high and gives
// at most one result per byte, registered at the transfer; the limit is the
// single parse path. The sync marker is kept in a 16-entry memory; the byte
// to compare is prefetched, so block sync checks run at full rate. After an
// error or a clean end the block is silent until reset. The user must write
// file_length over APB at address 0 while idle; the block does not check it.
module avro_container_deframer #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // file_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // payload_byte, record_count, block_length,
                                   // error_code
    output logic [3:0]  m_tuser,   // out_kind, codec_zstd
    output logic        m_tlast    // file_done
);
    import acd_pkg::*;

    localparam logic [64:0] LEN_LIMIT = 65'd1 << LENGTH_BITS;

    logic [31:0] file_length_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  shift_reg, shift_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] entries_reg, entries_next;
    logic [31:0] left_reg, left_next;
    logic [1:0]  kmatch_reg, kmatch_next;
    logic [1:0]  cmatch_reg, cmatch_next;
    logic        schema_reg, schema_next;
    logic        zstd_reg, zstd_next;
    logic        cvalid_reg, cvalid_next;
    logic [4:0]  sidx_reg, sidx_next;
    logic        err_reg, err_next;

    logic        outv_reg;
    result_t     out_reg, res;
    logic        res_v;

    logic        accept;
    logic [7:0]  sync_rd;
    logic [3:0]  rd_addr;
    logic        mem_we;

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_FILE_LENGTH) ? file_length_reg : 32'd0;
    assign s_tready = !outv_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = outv_reg;
    assign m_tdata  = {5'd0, out_reg.err, out_reg.blen, out_reg.rcount, out_reg.pbyte};
    assign m_tuser  = {out_reg.zstd, out_reg.kind};
    assign m_tlast  = out_reg.done;

    // The compare byte for the next sync position is always prefetched.
    assign rd_addr  = sidx_next[3:0];
    assign mem_we   = accept && !err_reg && phase_reg == PH_HSYNC;

    acd_sync_mem u_sync (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (sidx_reg[3:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (sync_rd)
    );

    always_comb
    begin
        logic        vphase, vdone, neg, clean;
        logic [63:0] acc_f;
        logic [64:0] mag;
        logic [2:0]  err;
        logic [31:0] remain;
        logic [64:0] ent_m;
        logic [63:0] vlen;

        phase_next = phase_reg;  acc_next = acc_reg;  shift_next = shift_reg;
        pos_next = pos_reg;  entries_next = entries_reg;  left_next = left_reg;
        kmatch_next = kmatch_reg;  cmatch_next = cmatch_reg;
        schema_next = schema_reg;  zstd_next = zstd_reg;  cvalid_next = cvalid_reg;
        sidx_next = sidx_reg;  err_next = err_reg;
        res = '0;  res_v = 1'b0;
        err = ERR_NONE;  clean = 1'b0;  neg = 1'b0;  mag = '0;  vdone = 1'b0;
        vphase = 1'b0;
        acc_f = acc_reg;  vlen = '0;
        remain = (file_length_reg > pos_next) ? file_length_reg - pos_next : 32'd0;
        ent_m = 65'(entries_reg);

        if (accept && !err_reg && phase_reg != PH_DONE)
        begin
            if (pos_reg != 32'hFFFF_FFFF)
            begin
                pos_next = pos_reg + 32'd1;
            end
            remain = (file_length_reg > pos_next) ? file_length_reg - pos_next : 32'd0;
            vphase = phase_reg inside {PH_MCOUNT, PH_MSIZE, PH_KLEN, PH_VLEN,
                                       PH_BCOUNT, PH_BLEN};
            if (vphase)
            begin
                acc_f = acc_reg | (64'(s_tdata[6:0]) << shift_reg);
                if (!s_tdata[7])
                begin
                    vdone = 1'b1;
                    neg = acc_f[0];
                    mag = neg ? 65'(acc_f[63:1]) + 65'd1 : 65'(acc_f[63:1]);
                    acc_next = '0;
                    shift_next = '0;
                end
                else if (shift_reg + 7'd7 > 7'd63)
                begin
                    err = ERR_VARINT;
                end
                else
                begin
                    acc_next = acc_f;
                    shift_next = shift_reg + 7'd7;
                end
            end

            if (!vphase || vdone)
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (pos_reg > 32'd3 || s_tdata != magic_at(pos_reg[1:0]))
                            err = ERR_MAGIC;
                        else if (pos_reg == 32'd3)
                            phase_next = PH_MCOUNT;
                    end
                    PH_MCOUNT:
                    begin
                        if (!neg && mag == '0)
                        begin
                            if (!schema_reg) err = ERR_SCHEMA;
                            else if (!cvalid_reg) err = ERR_CODEC;
                            else
                            begin
                                sidx_next = '0;
                                phase_next = PH_HSYNC;
                            end
                        end
                        else if (neg)
                        begin
                            entries_next = (mag > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
                            phase_next = PH_MSIZE;
                        end
                        else if (mag >= LEN_LIMIT || mag > 65'(remain))
                            err = ERR_RANGE;
                        else
                        begin
                            entries_next = mag[31:0];
                            phase_next = PH_KLEN;
                        end
                    end
                    PH_MSIZE:
                    begin
                        if (ent_m >= LEN_LIMIT || ent_m > 65'(remain))
                            err = ERR_RANGE;
                        else
                            phase_next = PH_KLEN;
                    end
                    PH_KLEN:
                    begin
                        if (neg || mag >= LEN_LIMIT || mag > 65'(remain))
                            err = ERR_RANGE;
                        else if (mag == '0)
                        begin
                            kmatch_next = 2'b00;
                            phase_next = PH_VLEN;
                        end
                        else
                        begin
                            kmatch_next = 2'b11;
                            left_next = mag[31:0];
                            phase_next = PH_KBYTES;
                        end
                    end
                    PH_KBYTES:
                    begin
                        if (acc_reg >= 64'd11 || s_tdata != schema_at(acc_reg[3:0]))
                            kmatch_next[0] = 1'b0;
                        if (acc_reg >= 64'd10 || s_tdata != codec_at(acc_reg[3:0]))
                            kmatch_next[1] = 1'b0;
                        acc_next = acc_reg + 64'd1;
                        left_next = left_reg - 32'd1;
                        if (left_next == 32'd0)
                        begin
                            if (acc_next != 64'd11) kmatch_next[0] = 1'b0;
                            if (acc_next != 64'd10) kmatch_next[1] = 1'b0;
                            acc_next = '0;
                            phase_next = PH_VLEN;
                        end
                    end
                    PH_VLEN:
                    begin
                        if (neg || mag >= LEN_LIMIT || mag > 65'(remain))
                            err = ERR_RANGE;
                        else
                        begin
                            cmatch_next = 2'b11;
                            if (mag == '0)
                                vdone = 1'b1;
                            else
                            begin
                                vdone = 1'b0;
                                left_next = mag[31:0];
                                phase_next = PH_VBYTES;
                            end
                        end
                    end
                    PH_VBYTES:
                    begin
                        if (acc_reg >= 64'd4 || s_tdata != null_at(acc_reg[3:0]))
                            cmatch_next[0] = 1'b0;
                        if (acc_reg >= 64'd9 || s_tdata != zstd_at(acc_reg[3:0]))
                            cmatch_next[1] = 1'b0;
                        acc_next = acc_reg + 64'd1;
                        left_next = left_reg - 32'd1;
                        vlen = acc_next;
                    end
                    PH_HSYNC:
                    begin
                        sidx_next = sidx_reg + 5'd1;
                        if (sidx_next >= 5'd16)
                        begin
                            res_v = 1'b1;
                            res.kind = KIND_HDR_DONE;
                            clean = 1'b1;
                            sidx_next = '0;
                            phase_next = PH_BCOUNT;
                        end
                    end
                    PH_BCOUNT:
                    begin
                        if (neg || mag >= LEN_LIMIT || mag > 65'hFFFF_FFFF)
                            err = ERR_RANGE;
                        else
                        begin
                            entries_next = mag[31:0];
                            phase_next = PH_BLEN;
                        end
                    end
                    PH_BLEN:
                    begin
                        if (neg || mag >= LEN_LIMIT || mag > 65'(remain) ||
                            (!zstd_reg && ent_m > mag))
                            err = ERR_RANGE;
                        else
                        begin
                            res_v = 1'b1;
                            res.kind = KIND_BLOCK;
                            res.rcount = entries_reg;
                            res.blen = mag[31:0];
                            left_next = mag[31:0];
                            sidx_next = '0;
                            phase_next = (mag != '0) ? PH_PAYLOAD : PH_BSYNC;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        res_v = 1'b1;
                        res.kind = KIND_PAYLOAD;
                        res.pbyte = s_tdata;
                        left_next = left_reg - 32'd1;
                        if (left_next == 32'd0)
                        begin
                            sidx_next = '0;
                            phase_next = PH_BSYNC;
                        end
                    end
                    PH_BSYNC:
                    begin
                        if (s_tdata != sync_rd)
                            err = ERR_SYNC;
                        else
                        begin
                            sidx_next = sidx_reg + 5'd1;
                            if (sidx_next >= 5'd16)
                            begin
                                res_v = 1'b1;
                                res.kind = KIND_SYNC_OK;
                                clean = 1'b1;
                                sidx_next = '0;
                                phase_next = PH_BCOUNT;
                            end
                        end
                    end
                    default: err = ERR_RANGE;
                endcase

                // Value finished: update schema and codec choice, count down the entries and pick the next phase.
                if (err == ERR_NONE &&
                    ((phase_reg == PH_VLEN && vdone) ||
                     (phase_reg == PH_VBYTES && left_next == 32'd0)))
                begin
                    if (kmatch_reg[0])
                        schema_next = (vlen != 64'd0);
                    if (kmatch_reg[1])
                    begin
                        zstd_next = cmatch_next[1] && vlen == 64'd9;
                        cvalid_next = zstd_next || (cmatch_next[0] && vlen == 64'd4);
                    end
                    acc_next = '0;
                    entries_next = entries_reg - 32'd1;
                    phase_next = (entries_next == 32'd0) ? PH_MCOUNT : PH_KLEN;
                end
            end

            if (err == ERR_NONE && s_tlast && !clean)
                err = (phase_next == PH_MAGIC) ? ERR_MAGIC : ERR_RANGE;
            if (err != ERR_NONE)
            begin
                err_next = 1'b1;
                res_v = 1'b1;
                res = '0;
                res.kind = KIND_ERROR;
                res.err = err;
                res.zstd = zstd_next;
            end
            else
            begin
                res.zstd = zstd_next;
                res.done = clean && s_tlast;
                if (clean && s_tlast)
                    phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            phase_reg <= PH_MAGIC;
            acc_reg <= '0;  shift_reg <= '0;  pos_reg <= '0;
            entries_reg <= '0;  left_reg <= '0;
            kmatch_reg <= 2'b11;  cmatch_reg <= 2'b11;
            schema_reg <= 1'b0;  zstd_reg <= 1'b0;  cvalid_reg <= 1'b1;
            sidx_reg <= '0;  err_reg <= 1'b0;
            outv_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_FILE_LENGTH)
                file_length_reg <= pwdata;
            phase_reg <= phase_next;
            acc_reg <= acc_next;  shift_reg <= shift_next;  pos_reg <= pos_next;
            entries_reg <= entries_next;  left_reg <= left_next;
            kmatch_reg <= kmatch_next;  cmatch_reg <= cmatch_next;
            schema_reg <= schema_next;  zstd_reg <= zstd_next;  cvalid_reg <= cvalid_next;
            sidx_reg <= sidx_next;  err_reg <= err_next;
            if (accept)
                outv_reg <= res_v;
            else if (m_tready)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_v)
            out_reg <= res;
    end

    a_sidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        sidx_reg < 5'd16) else $error("sync index out of range");
    a_silent_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg) else $error("error flag cleared");
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.kind == KIND_ERROR) |-> err_reg)
        else $error("error result without error state");
    a_done_stay: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("left done phase");
endmodule

// ===== design/acd_sync_mem.sv =====
// ============================================================================
// Sync marker store
// Holds the header sync marker; synchronous (registered) read.
// ============================================================================
module acd_sync_mem (
    input  logic       clk,
    input  logic       wr_en,
    input  logic [3:0] wr_addr,
    input  logic [7:0] wr_data,
    input  logic [3:0] rd_addr,
    output logic [7:0] rd_data
);
    logic [7:0] mem [16];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
